// ===== src/nco_mixer_fractional_decimator_assert.svh =====
// ----------------------------------------------------------------------------
// nco_mixer_fractional_decimator_assert.svh
// Assertion macros shared by the checker; sampled on clk, off while rst_n low.
// ----------------------------------------------------------------------------
`ifndef NCO_MIXER_FRACTIONAL_DECIMATOR_ASSERT_SVH
`define NCO_MIXER_FRACTIONAL_DECIMATOR_ASSERT_SVH

// same-cycle implication
`define NMFD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define NMFD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/nmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// nmfd_pkg
// Shared types, register codes, reset values and level thresholds.
// ----------------------------------------------------------------------------
package nmfd_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int ACC_BITS_DEF    = 32;

    localparam int STEP_W  = 32;
    localparam int RATE_W  = 16;
    localparam int GAP_W   = 18;
    localparam int SAMP_W  = 2;
    localparam int OUT_W   = 6;
    localparam int LEVEL_W = 5;
    localparam int CIDX_W  = 2;
    localparam int NUM_LEVELS = 8;

    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd2557223528;
    localparam logic [RATE_W-1:0] IN_RATE_RESET    = 16'd4000;
    localparam logic [RATE_W-1:0] OUT_RATE_RESET   = 16'd2048;
    localparam logic [GAP_W-1:0]  GAP_RESET        = GAP_W'(IN_RATE_RESET);

    // register index codes
    typedef enum logic [CIDX_W-1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_IN_RATE    = 2'd1,
        REG_OUT_RATE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [RATE_W-1:0] in_rate;
        logic [RATE_W-1:0] out_rate;
    } cfg_t;

    // acos(m/8)/(2*pi) in turns, 24 fraction bits
    typedef int unsigned edge_arr_t [NUM_LEVELS];
    localparam edge_arr_t LEVEL_EDGE = '{
        0, 1349401, 1929829, 2391584, 2796203, 3167899, 3519603, 3859657
    };

    // largest table offset j that still reaches level 8-k
    function automatic edge_arr_t level_thresholds(input int unsigned depth);
        edge_arr_t thr;
        longint unsigned prod;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            prod   = longint'(LEVEL_EDGE[k]) * longint'(depth);
            thr[k] = 32'(prod >> 24);
        end
        return thr;
    endfunction

    // front-end code to odd level -3, -1, 1, 3
    function automatic logic signed [2:0] sample_map(input logic [SAMP_W-1:0] code);
        logic signed [2:0] v;
        unique case (code)
            2'd0:    v = -3'sd3;
            2'd1:    v = -3'sd1;
            2'd2:    v = 3'sd1;
            default: v = 3'sd3;
        endcase
        return v;
    endfunction

endpackage

// ===== src/nco_mixer_fractional_decimator.sv =====
// ----------------------------------------------------------------------------
// nco_mixer_fractional_decimator: NCO mixer with fractional decimator
// One beat per cycle sustained while out_stall is low, set by the input
// register feeding one lookup-and-multiply stage.
// rst_n (async) zeroes the phase, loads the decimator gap and reset registers.
// ----------------------------------------------------------------------------
module nco_mixer_fractional_decimator #(
    // power of two; index is the top log2(TABLE_DEPTH) accumulator bits
    parameter int TABLE_DEPTH = nmfd_pkg::TABLE_DEPTH_DEF,
    parameter int ACC_BITS    = nmfd_pkg::ACC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nmfd_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [nmfd_pkg::STEP_W-1:0]        cfg_data,
    // raw sample channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [nmfd_pkg::SAMP_W-1:0]        raw_sample,
    // mixed output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [nmfd_pkg::OUT_W-1:0]  out_i,
    output logic signed [nmfd_pkg::OUT_W-1:0]  out_q
);

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);

    // Pipeline:
    //   front : on each accepted beat, the phase index is captured before the
    //           accumulator advances; the decimator decides keep/drop and only
    //           kept beats enter stage 1.
    //   mixer : stage 1 -> quarter-wave cosine/sine levels -> times the mapped
    //           sample -> output register.
    // The output register and stage 1 together act as a two-deep buffer, so a
    // new beat is taken while a finished result waits for its consumer.

    nmfd_pkg::cfg_t              cfg;
    logic                        s1_valid;
    logic [nmfd_pkg::SAMP_W-1:0] s1_sample;
    logic [IDX_BITS-1:0]         s1_idx;
    logic                        s1_adv;

    nmfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nmfd_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ACC_BITS    (ACC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_sample (raw_sample),
        .s1_adv     (s1_adv),
        .s1_valid   (s1_valid),
        .s1_sample  (s1_sample),
        .s1_idx     (s1_idx)
    );

    nmfd_mixer #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mixer (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_sample (s1_sample),
        .s1_idx    (s1_idx),
        .s1_adv    (s1_adv),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_i     (out_i),
        .out_q     (out_q)
    );

endmodule

// ===== src/nmfd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// nmfd_cfg_regs
// Configuration register file; always ready, unknown indexes ignored.
// ----------------------------------------------------------------------------
module nmfd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [nmfd_pkg::CIDX_W-1:0] cfg_index,
    input  logic [nmfd_pkg::STEP_W-1:0] cfg_data,
    output nmfd_pkg::cfg_t              cfg
);

    nmfd_pkg::cfg_t cfg_reg;
    nmfd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (nmfd_pkg::reg_idx_t'(cfg_index))
                nmfd_pkg::REG_PHASE_STEP: cfg_next.phase_step = cfg_data;
                nmfd_pkg::REG_IN_RATE:    cfg_next.in_rate  = cfg_data[nmfd_pkg::RATE_W-1:0];
                nmfd_pkg::REG_OUT_RATE:   cfg_next.out_rate = cfg_data[nmfd_pkg::RATE_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= nmfd_pkg::PHASE_STEP_RESET;
            cfg_reg.in_rate    <= nmfd_pkg::IN_RATE_RESET;
            cfg_reg.out_rate   <= nmfd_pkg::OUT_RATE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/nmfd_front.sv =====
// ----------------------------------------------------------------------------
// nmfd_front
// Input stage: phase accumulator, fractional decimator, stage-1 register.
// ----------------------------------------------------------------------------
module nmfd_front #(
    parameter int TABLE_DEPTH = nmfd_pkg::TABLE_DEPTH_DEF,
    parameter int ACC_BITS    = nmfd_pkg::ACC_BITS_DEF,
    localparam int IDX_BITS   = $clog2(TABLE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nmfd_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [nmfd_pkg::SAMP_W-1:0] raw_sample,
    input  logic                        s1_adv,
    output logic                        s1_valid,
    output logic [nmfd_pkg::SAMP_W-1:0] s1_sample,
    output logic [IDX_BITS-1:0]         s1_idx
);

    logic [ACC_BITS-1:0]              phase_acc_reg, phase_acc_next;
    logic [nmfd_pkg::GAP_W-1:0]       gap_reg, gap_next;
    logic                             s1_valid_reg, s1_valid_next;
    logic [nmfd_pkg::SAMP_W-1:0]      s1_sample_reg, s1_sample_next;
    logic [IDX_BITS-1:0]              s1_idx_reg, s1_idx_next;

    logic                             accept;
    logic                             keep;
    logic [nmfd_pkg::RATE_W-1:0]      eff_out;
    logic [nmfd_pkg::GAP_W-1:0]       gap_add;

    // stage 1 only blocks when it holds a beat the output cannot take
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign eff_out = (cfg.out_rate > cfg.in_rate) ? cfg.in_rate : cfg.out_rate;
    assign keep    = gap_reg < nmfd_pkg::GAP_W'(eff_out);
    assign gap_add = keep ? nmfd_pkg::GAP_W'(cfg.in_rate) : '0;

    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        gap_next       = gap_reg;
        s1_valid_next  = s1_valid_reg;
        s1_sample_next = s1_sample_reg;
        s1_idx_next    = s1_idx_reg;
        if (accept)
        begin
            phase_acc_next = phase_acc_reg + ACC_BITS'(cfg.phase_step);
            gap_next       = gap_reg + gap_add - nmfd_pkg::GAP_W'(eff_out);
            s1_sample_next = raw_sample;
            s1_idx_next    = phase_acc_reg[ACC_BITS-1 -: IDX_BITS];
        end
        if (s1_adv || !s1_valid_reg)
        begin
            s1_valid_next = accept && keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            gap_reg       <= nmfd_pkg::GAP_RESET;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
            gap_reg       <= gap_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= s1_sample_next;
        s1_idx_reg    <= s1_idx_next;
    end

    assign s1_valid  = s1_valid_reg;
    assign s1_sample = s1_sample_reg;
    assign s1_idx    = s1_idx_reg;

endmodule

// ===== src/nmfd_mixer.sv =====
// ----------------------------------------------------------------------------
// nmfd_mixer
// Cosine/sine level lookup, sample multiply and output register.
// ----------------------------------------------------------------------------
module nmfd_mixer #(
    parameter int TABLE_DEPTH = nmfd_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_BITS   = $clog2(TABLE_DEPTH)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s1_valid,
    input  logic [nmfd_pkg::SAMP_W-1:0]        s1_sample,
    input  logic [IDX_BITS-1:0]                s1_idx,
    output logic                               s1_adv,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [nmfd_pkg::OUT_W-1:0]  out_i,
    output logic signed [nmfd_pkg::OUT_W-1:0]  out_q
);

    localparam int OFS_W = IDX_BITS + 1;
    localparam logic [OFS_W-1:0] QUARTER   = OFS_W'(TABLE_DEPTH / 4);
    localparam logic [OFS_W-1:0] HALF      = OFS_W'(TABLE_DEPTH / 2);
    localparam logic [OFS_W-1:0] THREE_Q   = OFS_W'((3 * TABLE_DEPTH) / 4);
    localparam logic [OFS_W-1:0] FULL      = OFS_W'(TABLE_DEPTH);
    localparam logic [IDX_BITS-1:0] SIN_OFS = IDX_BITS'((3 * TABLE_DEPTH) / 4);
    localparam nmfd_pkg::edge_arr_t THR    = nmfd_pkg::level_thresholds(TABLE_DEPTH);

    // quarter-wave cosine: fold into first quadrant, count thresholds reached
    function automatic logic signed [nmfd_pkg::LEVEL_W-1:0] cos_level(
        input logic [IDX_BITS-1:0] idx
    );
        logic [OFS_W-1:0]             q;
        logic [OFS_W-1:0]             j;
        logic                         neg;
        logic [nmfd_pkg::LEVEL_W-1:0] mag;
        q = OFS_W'(idx);
        priority if (q <= QUARTER)
        begin
            j   = q;
            neg = 1'b0;
        end
        else if (q < HALF)
        begin
            j   = HALF - q;
            neg = 1'b1;
        end
        else if (q <= THREE_Q)
        begin
            j   = q - HALF;
            neg = 1'b1;
        end
        else
        begin
            j   = FULL - q;
            neg = 1'b0;
        end
        mag = '0;
        for (int k = 0; k < nmfd_pkg::NUM_LEVELS; k++)
        begin
            if (j <= OFS_W'(THR[k]))
            begin
                mag = mag + 1'b1;
            end
        end
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    logic                              out_valid_reg, out_valid_next;
    logic signed [nmfd_pkg::OUT_W-1:0] out_i_reg, out_i_next;
    logic signed [nmfd_pkg::OUT_W-1:0] out_q_reg, out_q_next;

    logic signed [nmfd_pkg::LEVEL_W-1:0] cos_lvl;
    logic signed [nmfd_pkg::LEVEL_W-1:0] sin_lvl;
    logic signed [7:0]                   samp_ext;
    logic signed [7:0]                   prod_i;
    logic signed [7:0]                   prod_q;

    assign s1_adv = !out_valid_reg || !out_stall;

    assign cos_lvl  = cos_level(s1_idx);
    assign sin_lvl  = -cos_level(s1_idx + SIN_OFS);
    assign samp_ext = 8'(nmfd_pkg::sample_map(s1_sample));
    assign prod_i   = samp_ext * 8'(cos_lvl);
    assign prod_q   = samp_ext * 8'(sin_lvl);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_i_next     = out_i_reg;
        out_q_next     = out_q_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid;
            if (s1_valid)
            begin
                out_i_next = prod_i[nmfd_pkg::OUT_W-1:0];
                out_q_next = prod_q[nmfd_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_i_reg <= out_i_next;
        out_q_reg <= out_q_next;
    end

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

endmodule

// ===== src/nmfd_checker.sv =====
// ----------------------------------------------------------------------------
// nmfd_port_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "nco_mixer_fractional_decimator_assert.svh"

module nmfd_port_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [nmfd_pkg::OUT_W-1:0]  out_i,
    input  logic signed [nmfd_pkg::OUT_W-1:0]  out_q
);

    localparam int OUT_LIM = 24;

    logic out_in_range;

    // product magnitude bounded by 3 * 8
    assign out_in_range = (out_i >= -OUT_LIM) && (out_i <= OUT_LIM) &&
                          (out_q >= -OUT_LIM) && (out_q <= OUT_LIM);

    // stalled result beat holds
    `NMFD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable({out_i, out_q}))

    // input only backs up when both buffer slots are full
    `NMFD_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    `NMFD_ASSERT_IMP(a_out_range, out_valid, out_in_range)

    // a fresh result beat comes from an accepted beat that passed stage 1 and the output register
    `NMFD_ASSERT_IMP(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind nco_mixer_fractional_decimator nmfd_port_checker u_nmfd_port_checker (.*);
